// ----- hdl/vgse_pkg.sv -----
// ----------------------------------------------------------------------------
// vgse_pkg
// Shared sizes, field widths and command codes of the voxel grid editor.
// ----------------------------------------------------------------------------
`default_nettype none

package vgse_pkg;

  // Grid geometry
  localparam int MAX_DIM   = 16;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int CNT_W     = $clog2(MAX_DIM + 1);
  localparam int ADDR_W    = 3 * DIM_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // Field widths
  localparam int CMD_W     = 4;
  localparam int POS_W     = 11;
  localparam int RAD_W     = 10;
  localparam int SIZE_W    = 5;
  localparam int CFG_IDX_W = 2;

  // Arithmetic widths: offsets from the centre, squares and their sums
  localparam int D_W   = POS_W + 1;
  localparam int SUM_W = 2 * D_W + 2;
  localparam int BND_W = D_W - 5;
  localparam int PT_W  = POS_W - 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_GET        = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SET        = 4'd1;
  localparam logic [CMD_W-1:0] CMD_CLR        = 4'd2;
  localparam logic [CMD_W-1:0] CMD_TOG        = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_FILL_ALL   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ADD        = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SUB        = 4'd7;
  localparam logic [CMD_W-1:0] CMD_TOG_SPHERE = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

endpackage

`default_nettype wire

// ----- hdl/vgse_if.sv -----
// ----------------------------------------------------------------------------
// vgse_if
// Valid/ready channels for commands and for their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface vgse_cmd_if;
  import vgse_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [RAD_W-1:0]        radius;

  modport source (output valid, command, pos_x, pos_y, pos_z, radius, input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, radius, output ready);
endinterface

interface vgse_rsp_if;
  logic valid;
  logic ready;
  logic voxel_value;
  logic out_of_range;

  modport source (output valid, voxel_value, out_of_range, input ready);
  modport sink (input valid, voxel_value, out_of_range, output ready);
endinterface

`default_nettype wire

// ----- hdl/voxel_grid_sphere_editor.sv -----
// ----------------------------------------------------------------------------
// voxel_grid_sphere_editor
// One-bit-per-voxel occupancy grid with point, whole-grid and sphere edits.
// ----------------------------------------------------------------------------
// Point commands: the read state, then the modify state, then the result is registered.
// Clear all / fill all: a sweep writes every voxel, then the result is registered.
// Spheres: setup, then dx squared per plane, dy and dz squared per row and a walk over
// the clipped box; an empty axis skips the walk. One squarer, one voxel a cycle in a row.
// A new result holds in the last state while the previous one is still waiting.
// Reset: synchronous; a clearing pass over all 4096 voxels follows, no command taken.
`default_nettype none

module voxel_grid_sphere_editor (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [vgse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vgse_pkg::SIZE_W-1:0]    cfg_data,
  vgse_cmd_if.sink                            cmd,
  vgse_rsp_if.source                          rsp
);
  import vgse_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;  // sweep the whole store
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PT_RD  = 4'd2;  // read the addressed voxel
  localparam logic [3:0] S_PT_WR  = 4'd3;  // modify it and capture the read
  localparam logic [3:0] S_SETUP  = 4'd4;  // clip the box, square the radius
  localparam logic [3:0] S_XSQ    = 4'd5;  // dx squared for a new plane
  localparam logic [3:0] S_YSQ    = 4'd6;  // dy squared for a new row
  localparam logic [3:0] S_ZSQ    = 4'd7;  // dz squared at row start, dx2 + dy2
  localparam logic [3:0] S_ZWALK  = 4'd8;  // one voxel of the row per cycle
  localparam logic [3:0] S_FINISH = 4'd9;  // hand the result to the output

  typedef struct packed {
    logic [DIM_W-1:0] lo;
    logic [CNT_W-1:0] hi;
    logic             empty;
  } box_t;

  typedef struct packed {
    logic [DIM_W-1:0] idx;
    logic             ok;
  } pt_t;

  // Size register clamped to the grid
  function automatic logic [CNT_W-1:0] used_size(input logic [SIZE_W-1:0] s);
    if (int'(s) > MAX_DIM) return CNT_W'(MAX_DIM);
    return CNT_W'(s);
  endfunction

  // Clipped box along one axis: truncate(c-r) up to truncate(c+r), within [0,n)
  function automatic box_t box_axis(input logic signed [POS_W-1:0] c,
                                    input logic [RAD_W-1:0] r,
                                    input logic [CNT_W-1:0] n);
    logic signed [D_W-1:0] ce;
    logic signed [D_W-1:0] re;
    logic signed [D_W-1:0] a;
    logic signed [D_W-1:0] b;
    logic [BND_W-1:0]      a_t;
    logic [BND_W-1:0]      b_t;
    logic [BND_W-1:0]      hi_c;
    box_t                  bx;
    ce   = {c[POS_W-1], c};
    re   = {{(D_W-RAD_W){1'b0}}, r};
    a    = ce - re;
    b    = ce + re;
    // a negative bound truncates to zero or below: both clip to zero
    a_t  = a[D_W-1] ? '0 : a[D_W-2:4];
    b_t  = b[D_W-1] ? '0 : b[D_W-2:4];
    hi_c = (b_t < BND_W'(n)) ? b_t : BND_W'(n);
    bx.lo    = a_t[DIM_W-1:0];
    bx.hi    = hi_c[CNT_W-1:0];
    bx.empty = (a_t >= hi_c);
    return bx;
  endfunction

  // Integer part of a point coordinate; anything within one voxel below zero
  // still truncates to voxel zero
  function automatic pt_t pt_axis(input logic signed [POS_W-1:0] p,
                                  input logic [CNT_W-1:0] n);
    logic [PT_W-1:0] t;
    pt_t             pt;
    t      = p[POS_W-1] ? '0 : p[POS_W-2:4];
    pt.idx = t[DIM_W-1:0];
    pt.ok  = (p > -16) && (BND_W'(t) < BND_W'(n));
    return pt;
  endfunction

  // Configuration
  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;
  logic [CNT_W-1:0]  used_x;
  logic [CNT_W-1:0]  used_y;
  logic [CNT_W-1:0]  used_z;

  // Sequencer and command registers
  logic [3:0]              state;
  logic [CMD_W-1:0]        op;
  logic signed [POS_W-1:0] cx;
  logic signed [POS_W-1:0] cy;
  logic signed [POS_W-1:0] cz;
  logic [RAD_W-1:0]        rad;
  logic                    pt_ok;
  logic                    res_value;
  logic                    res_oor;

  // Sweep
  logic [ADDR_W-1:0] sweep_cnt;
  logic              sweep_val;
  logic              sweep_report;

  // Walk counters, also the point address
  logic [DIM_W-1:0] i;
  logic [DIM_W-1:0] j;
  logic [DIM_W-1:0] k;
  logic [DIM_W-1:0] y_lo;
  logic [DIM_W-1:0] z_lo;
  logic [CNT_W-1:0] x_hi;
  logic [CNT_W-1:0] y_hi;
  logic [CNT_W-1:0] z_hi;

  // Distance datapath
  logic signed [D_W-1:0]   sq_in;
  logic signed [2*D_W-1:0] prod;
  logic [SUM_W-1:0]        sq_val;
  logic [SUM_W-1:0]        r2;
  logic [SUM_W-1:0]        sq_x;
  logic [SUM_W-1:0]        sq_y;
  logic [SUM_W-1:0]        sxy;
  logic [SUM_W-1:0]        sq_z;
  logic [SUM_W-1:0]        sq_z_next;
  logic [SUM_W-1:0]        dz_ext;
  logic signed [D_W-1:0]   dz;
  logic                    hit;
  logic                    last_i;
  logic                    last_j;
  logic                    last_k;

  // Store and its write stage
  logic              mem [0:MEM_DEPTH-1];
  logic              rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic              wd;

  // Output register
  logic rsp_valid;
  logic rsp_value;
  logic rsp_oor;

  box_t bx_x;
  box_t bx_y;
  box_t bx_z;
  pt_t  pa_x;
  pt_t  pa_y;
  pt_t  pa_z;

  assign used_x = used_size(size_x);
  assign used_y = used_size(size_y);
  assign used_z = used_size(size_z);

  assign pa_x = pt_axis(cmd.pos_x, used_x);
  assign pa_y = pt_axis(cmd.pos_y, used_y);
  assign pa_z = pt_axis(cmd.pos_z, used_z);

  assign bx_x = box_axis(cx, rad, used_x);
  assign bx_y = box_axis(cy, rad, used_y);
  assign bx_z = box_axis(cz, rad, used_z);

  assign cmd.ready        = (state == S_IDLE);
  assign rsp.valid        = rsp_valid;
  assign rsp.voxel_value  = rsp_value;
  assign rsp.out_of_range = rsp_oor;

  // Shared squarer: radius, then offsets from the centre to the voxel corner
  always_comb begin
    unique case (state)
      S_SETUP: sq_in = {{(D_W-RAD_W){1'b0}}, rad};
      S_XSQ:   sq_in = {cx[POS_W-1], cx} - {{(D_W-DIM_W-4){1'b0}}, i, 4'b0000};
      S_YSQ:   sq_in = {cy[POS_W-1], cy} - {{(D_W-DIM_W-4){1'b0}}, j, 4'b0000};
      default: sq_in = {cz[POS_W-1], cz} - {{(D_W-DIM_W-4){1'b0}}, z_lo, 4'b0000};
    endcase
  end

  assign prod   = sq_in * sq_in;
  assign sq_val = {2'b00, prod};

  // Stepping k by one moves dz by -16: (dz-16)^2 = dz^2 - 32*dz + 256
  assign dz_ext    = {{(SUM_W-D_W){dz[D_W-1]}}, dz};
  assign sq_z_next = sq_z - (dz_ext << 5) + SUM_W'(256);
  assign hit       = ((sxy + sq_z) < r2);

  assign last_k = ((CNT_W'(k) + CNT_W'(1)) == z_hi);
  assign last_j = ((CNT_W'(j) + CNT_W'(1)) == y_hi);
  assign last_i = ((CNT_W'(i) + CNT_W'(1)) == x_hi);

  assign rd_addr = {i, j, k};

  // Store write port: sweep, pending sphere update, or point update
  always_comb begin
    we = 1'b0;
    wa = rd_addr;
    wd = 1'b0;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wa = sweep_cnt;
      wd = sweep_val;
    end else if (pend) begin
      we = 1'b1;
      wa = pend_addr;
      wd = (op == CMD_ADD) ? 1'b1 : ((op == CMD_SUB) ? 1'b0 : ~rd_data);
    end else if (state == S_PT_WR && pt_ok && op != CMD_GET) begin
      we = 1'b1;
      wd = (op == CMD_SET) ? 1'b1 : ((op == CMD_CLR) ? 1'b0 : ~rd_data);
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sweep_cnt    <= '0;
      sweep_val    <= 1'b0;
      sweep_report <= 1'b0;
      pend         <= 1'b0;
      rsp_valid    <= 1'b0;
      size_x       <= SIZE_RST;
      size_y       <= SIZE_RST;
      size_z       <= SIZE_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE_X: size_x <= cfg_data;
          REG_SIZE_Y: size_y <= cfg_data;
          REG_SIZE_Z: size_z <= cfg_data;
          default: ;
        endcase
      end

      // The sphere write stage clears unless the walk refills it; drop the taken result
      pend <= 1'b0;
      if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == '1) begin
            state <= sweep_report ? S_FINISH : S_IDLE;
          end
        end

        S_IDLE: begin
          if (cmd.valid) begin
            op        <= cmd.command;
            cx        <= cmd.pos_x;
            cy        <= cmd.pos_y;
            cz        <= cmd.pos_z;
            rad       <= cmd.radius;
            res_value <= 1'b0;
            res_oor   <= 1'b0;
            unique case (cmd.command) inside
              CMD_GET, CMD_SET, CMD_CLR, CMD_TOG: begin
                i       <= pa_x.idx;
                j       <= pa_y.idx;
                k       <= pa_z.idx;
                pt_ok   <= pa_x.ok && pa_y.ok && pa_z.ok;
                res_oor <= !(pa_x.ok && pa_y.ok && pa_z.ok);
                state   <= S_PT_RD;
              end
              CMD_CLEAR_ALL, CMD_FILL_ALL: begin
                sweep_val    <= (cmd.command == CMD_FILL_ALL);
                sweep_report <= 1'b1;
                sweep_cnt    <= '0;
                state        <= S_CLEAR;
              end
              CMD_ADD, CMD_SUB, CMD_TOG_SPHERE: begin
                state <= S_SETUP;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end

        S_PT_RD: begin
          state <= S_PT_WR;
        end

        S_PT_WR: begin
          if (pt_ok && op == CMD_GET) begin
            res_value <= rd_data;
          end
          state <= S_FINISH;
        end

        S_SETUP: begin
          r2   <= sq_val;
          i    <= bx_x.lo;
          y_lo <= bx_y.lo;
          z_lo <= bx_z.lo;
          x_hi <= bx_x.hi;
          y_hi <= bx_y.hi;
          z_hi <= bx_z.hi;
          // An empty box on any axis leaves the grid untouched
          state <= (bx_x.empty || bx_y.empty || bx_z.empty) ? S_FINISH : S_XSQ;
        end

        S_XSQ: begin
          sq_x  <= sq_val;
          j     <= y_lo;
          state <= S_YSQ;
        end

        S_YSQ: begin
          sq_y  <= sq_val;
          state <= S_ZSQ;
        end

        S_ZSQ: begin
          sq_z  <= sq_val;
          dz    <= sq_in;
          sxy   <= sq_x + sq_y;
          k     <= z_lo;
          state <= S_ZWALK;
        end

        S_ZWALK: begin
          // Read issued now; the update lands next cycle on the returned bit
          pend      <= hit;
          pend_addr <= rd_addr;
          k         <= k + 1'b1;
          dz        <= dz - D_W'(16);
          sq_z      <= sq_z_next;
          if (last_k) begin
            if (!last_j) begin
              j     <= j + 1'b1;
              state <= S_YSQ;
            end else if (!last_i) begin
              i     <= i + 1'b1;
              state <= S_XSQ;
            end else begin
              state <= S_FINISH;
            end
          end
        end

        S_FINISH: begin
          // Hold here only while the previous result is still waiting
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_value <= res_value;
            rsp_oor   <= res_oor;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- test/voxel_grid_sphere_editor_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voxel_grid_sphere_editor_test
// Self-checking bench for the voxel grid editor. A behavioural copy of the
// occupancy grid predicts the reply to every command. Directed point, whole
// grid, sphere and size cases come first, then random phases under changing
// sizes, with random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------

module voxel_grid_sphere_editor_test;
  import vgse_pkg::*;

  // Commands the block does not decode; they must come back as all-zero replies
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_TOG_SPHERE + 1'b1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  // Longest stretch with no transaction on either channel, well above a full-box
  // sphere or the clearing pass after reset.
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // Position of one voxel step in Q7.4 units
  localparam int VOXEL_STEP = 16;

  typedef struct packed {
    logic voxel_value;
    logic out_of_range;
  } grid_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SIZE_X;
  logic [SIZE_W-1:0]    cfg_data = '0;

  vgse_cmd_if cmd ();
  vgse_rsp_if rsp ();

  voxel_grid_sphere_editor uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predicted grid: one bit per voxel at x*256 + y*16 + z, plus the size
  // registers as last written. Replies still owed by the block queue up here.
  // --------------------------------------------------------------------------
  bit                occupancy [MEM_DEPTH];
  logic [SIZE_W-1:0] grid_size [3];
  grid_reply_t       replies_due [$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned rsp_hold = 0;
  bit          quiet_cmd = 1'b0;   // no gaps between commands
  bit          quiet_rsp = 1'b0;   // no back-pressure on replies

  // Register values above the grid dimension saturate at it
  function automatic int voxels_in_use(input logic [SIZE_W-1:0] size_reg);
    return (size_reg > MAX_DIM) ? MAX_DIM : int'(size_reg);
  endfunction

  // Apply one command to the predicted grid and return the reply it owes.
  // Integer division truncates toward zero, as the block's Q7.4 integer part.
  function automatic grid_reply_t edit_grid(input logic [CMD_W-1:0] op,
                                            input logic signed [POS_W-1:0] px,
                                            input logic signed [POS_W-1:0] py,
                                            input logic signed [POS_W-1:0] pz,
                                            input logic [RAD_W-1:0] rad);
    grid_reply_t reply;
    int          ctr [3];
    int          span [3];
    int          lo [3];
    int          hi [3];
    int          vox [3];
    int          r;
    int          a;
    int          i;
    int          j;
    int          k;
    int          dx;
    int          dy;
    int          dz;
    int          slot;
    reply = '0;
    ctr[0] = px;
    ctr[1] = py;
    ctr[2] = pz;
    r = rad;
    for (a = 0; a < 3; a++) begin
      span[a] = voxels_in_use(grid_size[a]);
      vox[a] = ctr[a] / VOXEL_STEP;
    end
    if (op <= CMD_TOG) begin
      if (vox[0] < 0 || vox[1] < 0 || vox[2] < 0 || vox[0] >= span[0] ||
          vox[1] >= span[1] || vox[2] >= span[2]) begin
        reply.out_of_range = 1'b1;
      end else begin
        slot = (vox[0] * MAX_DIM + vox[1]) * MAX_DIM + vox[2];
        case (op)
          CMD_GET: reply.voxel_value = occupancy[slot];
          CMD_SET: occupancy[slot] = 1'b1;
          CMD_CLR: occupancy[slot] = 1'b0;
          default: occupancy[slot] = ~occupancy[slot];
        endcase
      end
    end else if (op == CMD_CLEAR_ALL) begin
      occupancy = '{default: 1'b0};
    end else if (op == CMD_FILL_ALL) begin
      occupancy = '{default: 1'b1};
    end else if (op <= CMD_TOG_SPHERE) begin
      // Clip the bounding box, then test each voxel corner strictly inside r
      for (a = 0; a < 3; a++) begin
        lo[a] = (ctr[a] - r) / VOXEL_STEP;
        hi[a] = (ctr[a] + r) / VOXEL_STEP;
        if (lo[a] < 0) lo[a] = 0;
        if (hi[a] > span[a]) hi[a] = span[a];
      end
      for (i = lo[0]; i < hi[0]; i++) begin
        for (j = lo[1]; j < hi[1]; j++) begin
          for (k = lo[2]; k < hi[2]; k++) begin
            dx = ctr[0] - i * VOXEL_STEP;
            dy = ctr[1] - j * VOXEL_STEP;
            dz = ctr[2] - k * VOXEL_STEP;
            if (dx * dx + dy * dy + dz * dz < r * r) begin
              slot = (i * MAX_DIM + j) * MAX_DIM + k;
              case (op)
                CMD_ADD: occupancy[slot] = 1'b1;
                CMD_SUB: occupancy[slot] = 1'b0;
                default: occupancy[slot] = ~occupancy[slot];
              endcase
            end
          end
        end
      end
    end
    return reply;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Command side. Valid stays high across back-to-back transactions; it is
  // only dropped when a gap is drawn or the bench waits for idle, so it never falls and rises in one step.
  // The grid prediction is made at the edge that accepts the command.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input logic [CMD_W-1:0] op,
                          input logic signed [POS_W-1:0] px,
                          input logic signed [POS_W-1:0] py,
                          input logic signed [POS_W-1:0] pz,
                          input logic [RAD_W-1:0] rad);
    int unsigned gap;
    gap = quiet_cmd ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid   <= 1'b1;
    cmd.command <= op;
    cmd.pos_x   <= px;
    cmd.pos_y   <= py;
    cmd.pos_z   <= pz;
    cmd.radius  <= rad;
    @(posedge clk);
    while (cmd.ready !== 1'b1) @(posedge clk);
    replies_due.push_back(edit_grid(op, px, py, pz, rad));
  endtask

  // Drop valid and hold until every reply owed has come back
  task automatic wait_idle();
    cmd.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Write all three size registers with the write enable held throughout
  task automatic set_sizes(input logic [SIZE_W-1:0] sx,
                           input logic [SIZE_W-1:0] sy,
                           input logic [SIZE_W-1:0] sz);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIZE_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= REG_SIZE_Y;
    cfg_data  <= sy;
    @(posedge clk);
    cfg_index <= REG_SIZE_Z;
    cfg_data  <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    grid_size[REG_SIZE_X] = sx;
    grid_size[REG_SIZE_Y] = sy;
    grid_size[REG_SIZE_Z] = sz;
  endtask

  // --------------------------------------------------------------------------
  // Reply side: check each transaction against the oldest prediction, then
  // draw how long to hold ready low before the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    grid_reply_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply with no command outstanding");
      end else begin
        want = replies_due.pop_front();
        if (rsp.voxel_value !== want.voxel_value)
          report_mismatch($sformatf("voxel_value: expected %0b, got %0b",
                                    want.voxel_value, rsp.voxel_value));
        if (rsp.out_of_range !== want.out_of_range)
          report_mismatch($sformatf("out_of_range: expected %0b, got %0b",
                                    want.out_of_range, rsp.out_of_range));
      end
      rsp_hold = quiet_rsp ? 0 : $urandom_range(0, 11);
    end else if (rsp_hold != 0) begin
      rsp_hold--;
    end
    rsp.ready <= (rsp_hold == 0);
  end

  // Watchdog: give up when neither channel has moved for too long
  always @(posedge clk) begin
    if ((cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly 1..16, sometimes zero or above the grid dimension
  function automatic logic [SIZE_W-1:0] draw_size();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return SIZE_W'($urandom_range(MAX_DIM + 1, (1 << SIZE_W) - 1));
    return SIZE_W'($urandom_range(1, MAX_DIM));
  endfunction

  // Aim a coordinate inside the axis in use, now and then just outside it
  function automatic logic signed [POS_W-1:0] aim_coord(input logic [SIZE_W-1:0] size_reg);
    int span;
    int pick;
    int off;
    span = voxels_in_use(size_reg) * VOXEL_STEP;
    pick = $urandom_range(0, 9);
    if (span == 0 || pick == 0) begin
      off = $urandom_range(1, 48);
      return POS_W'(-off);
    end
    if (pick == 1) return POS_W'(span + $urandom_range(0, 31));
    return POS_W'($urandom_range(0, span - 1));
  endfunction

  // Mostly point edits and reads aimed at the grid so state gets observed;
  // small spheres, rare whole-grid passes, unused codes and raw noise.
  task automatic send_random_cmd();
    int unsigned        pick;
    logic [CMD_W-1:0]   op;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [RAD_W-1:0]   rad;
    pick = $urandom_range(0, 99);
    px = aim_coord(grid_size[REG_SIZE_X]);
    py = aim_coord(grid_size[REG_SIZE_Y]);
    pz = aim_coord(grid_size[REG_SIZE_Z]);
    rad = ($urandom_range(0, 9) == 0) ? RAD_W'($urandom_range(0, 160))
                                      : RAD_W'($urandom_range(0, 40));
    if (pick < 35) op = CMD_GET;
    else if (pick < 45) op = CMD_SET;
    else if (pick < 55) op = CMD_CLR;
    else if (pick < 63) op = CMD_TOG;
    else if (pick < 69) op = CMD_ADD;
    else if (pick < 74) op = CMD_SUB;
    else if (pick < 79) op = CMD_TOG_SPHERE;
    else if (pick < 81) op = $urandom_range(0, 1) ? CMD_CLEAR_ALL : CMD_FILL_ALL;
    else if (pick < 85) op = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else begin
      op  = CMD_W'($urandom);
      px  = POS_W'($urandom);
      py  = POS_W'($urandom);
      pz  = POS_W'($urandom);
      rad = RAD_W'($urandom);
    end
    send_cmd(op, px, py, pz, rad);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Single-voxel edits, truncation toward zero, out-of-range points, and the
  // field extremes; unused codes must leave the grid alone
  task automatic test_point_commands();
    send_cmd(CMD_GET, 11'sd0, 11'sd0, 11'sd0, '0);
    send_cmd(CMD_SET, 11'sd255, 11'sd255, 11'sd255, '0);
    send_cmd(CMD_GET, 11'sd255, 11'sd255, 11'sd255, '1);
    // -0.5 truncates to voxel 0, not -1
    send_cmd(CMD_TOG, -11'sd8, 11'sd0, 11'sd0, '0);
    send_cmd(CMD_GET, -11'sd8, -11'sd15, -11'sd1, '0);
    send_cmd(CMD_CLR, 11'sd0, 11'sd0, 11'sd0, '0);
    // -1.0 and the field extremes fall outside; set must not touch the grid
    send_cmd(CMD_GET, -11'sd16, 11'sd0, 11'sd0, '0);
    send_cmd(CMD_SET, 11'sd1023, 11'sd1023, 11'sd1023, '1);
    send_cmd(CMD_GET, -11'sd1024, -11'sd1024, -11'sd1024, '1);
    send_cmd(CMD_UNUSED_LO, 11'sd0, 11'sd0, 11'sd0, '0);
    send_cmd(CMD_UNUSED_HI, 11'sd255, 11'sd255, 11'sd255, '1);
    send_cmd(CMD_GET, 11'sd255, 11'sd255, 11'sd255, '0);
  endtask

  task automatic test_whole_grid();
    send_cmd(CMD_FILL_ALL, 11'sd0, 11'sd0, 11'sd0, '0);
    send_cmd(CMD_GET, 11'sd100, 11'sd37, 11'sd200, '0);
    send_cmd(CMD_CLEAR_ALL, 11'sd0, 11'sd0, 11'sd0, '0);
    send_cmd(CMD_GET, 11'sd100, 11'sd37, 11'sd200, '0);
  endtask

  // Add, carve and toggle; zero radius, a box wholly outside the grid, and
  // radius at its top so the box covers every voxel
  task automatic test_spheres();
    send_cmd(CMD_ADD, 11'sd128, 11'sd128, 11'sd128, 10'd48);
    send_cmd(CMD_GET, 11'sd160, 11'sd128, 11'sd128, '0);
    send_cmd(CMD_SUB, 11'sd128, 11'sd128, 11'sd128, 10'd17);
    send_cmd(CMD_GET, 11'sd128, 11'sd128, 11'sd128, '0);
    send_cmd(CMD_TOG_SPHERE, 11'sd128, 11'sd128, 11'sd128, 10'd0);
    send_cmd(CMD_ADD, -11'sd1024, -11'sd1024, -11'sd1024, '1);
    send_cmd(CMD_TOG_SPHERE, 11'sd1023, 11'sd1023, 11'sd1023, '1);
    send_cmd(CMD_GET, 11'sd0, 11'sd0, 11'sd0, '0);
  endtask

  // Tiny grid, an empty axis, and registers above the grid dimension
  task automatic test_sizes();
    wait_idle();
    set_sizes(5'd1, 5'd1, 5'd1);
    send_cmd(CMD_ADD, 11'sd8, 11'sd8, 11'sd8, '1);
    send_cmd(CMD_GET, 11'sd16, 11'sd0, 11'sd0, '0);
    wait_idle();
    set_sizes(5'd0, 5'd5, 5'd31);
    send_cmd(CMD_TOG_SPHERE, 11'sd8, 11'sd8, 11'sd8, '1);
    send_cmd(CMD_GET, 11'sd0, 11'sd0, 11'sd0, '0);
    wait_idle();
    set_sizes(5'd31, 5'd17, 5'd16);
    send_cmd(CMD_GET, 11'sd255, 11'sd255, 11'sd255, '0);
  endtask

  // Random phases, each under fresh sizes and its own idling pattern
  task automatic test_random();
    int phase;
    int n;
    for (phase = 0; phase < 5; phase++) begin
      wait_idle();
      quiet_cmd = ($urandom_range(0, 3) == 0);
      quiet_rsp = ($urandom_range(0, 3) == 0);
      if (phase == 0) set_sizes(SIZE_RST, SIZE_RST, SIZE_RST);
      else set_sizes(draw_size(), draw_size(), draw_size());
      for (n = 0; n < 22; n++) send_random_cmd();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset once, then each test in turn, drain, and report
  // --------------------------------------------------------------------------
  initial begin
    cmd.valid    = 1'b0;
    cmd.command  = CMD_GET;
    cmd.pos_x    = '0;
    cmd.pos_y    = '0;
    cmd.pos_z    = '0;
    cmd.radius   = '0;
    rsp.ready    = 1'b0;
    occupancy    = '{default: 1'b0};
    grid_size[0] = SIZE_RST;
    grid_size[1] = SIZE_RST;
    grid_size[2] = SIZE_RST;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_point_commands();
    test_whole_grid();
    test_spheres();
    test_sizes();
    test_random();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
